/* sv/nra_pkg.sv */
package nra_pkg;

    localparam int REG_W           = 13;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int IDX_W           = 24;
    localparam int COORD_W         = 12;

    localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DEST_WIDTH    = 2'd2;
    localparam logic [1:0] CFG_DEST_HEIGHT   = 2'd3;

    typedef struct packed {
        logic restart;
    } tick_t;

    typedef struct packed {
        logic [IDX_W-1:0]   dest_index;
        logic [IDX_W-1:0]   source_index;
        logic [COORD_W-1:0] source_col;
        logic [COORD_W-1:0] source_row;
        logic               frame_last;
        logic               edge_clamped;
    } pixel_t;

    typedef struct packed {
        logic div_start;
        logic load_step;
        logic wrap_pos;
        logic mul_pos;
        logic clamp;
        logic mul_src;
        logic out_load;
    } nra_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } nra_stat_t;

endpackage

/* sv/nra_chan_if.sv */
interface nra_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* sv/nearest_resize_address_gen_unit.sv */
// A tick with restart first runs the bit-serial ratio divide and loads the step ratios; each
// tick then passes the position, multiply, clamp, source multiply and output load states.
// The controller takes no new tick until the last word is loaded, and it holds while the output
// is busy; it sequences position, multiply, clamp and index steps for one word at a time.
// Reset: asynchronous, active low; sizes read as 1, ratios and position clear to zero.
module nearest_resize_address_gen_unit import nra_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    nra_chan_if.sink         tick,
    nra_chan_if.source       pixel
);
    nra_cmd_t  cmd;
    nra_stat_t stat;
    tick_t     tick_word;
    pixel_t    pixel_word;

    assign tick_word  = tick.data;
    assign pixel.data = pixel_word;

    nra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (tick.valid),
        .in_restart (tick_word.restart),
        .in_ready   (tick.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    nra_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (pixel.ready),
        .out_valid (pixel.valid),
        .out_data  (pixel_word)
    );

    a_no_tick_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_busy |-> !tick.ready)
        else $error("tick taken during ratio divide");

    a_plain_tick_no_divide: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready && !tick_word.restart |=> !stat.div_busy)
        else $error("divider started without restart");

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_load_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> pixel.valid)
        else $error("loaded word not presented");
endmodule

/* sv/nra_divider.sv */
// Restoring divider, one quotient bit per cycle.
module nra_divider #(
    parameter int N = 29,
    parameter int D = 13
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         busy,
    output logic [N-1:0] quotient
);
    localparam int CNT_W = (N > 1) ? $clog2(N) : 1;

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D-1:0]     rem_reg;
    logic [N-1:0]     quo_reg;

    logic [D:0]   trial;
    logic [D:0]   diff;
    logic         ge;
    logic [D-1:0] rem_next;
    logic [N-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[N-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? diff[D-1:0] : trial[D-1:0];
        quo_next = {quo_reg[N-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(N - 1))
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

/* sv/nra_datapath.sv */
module nra_datapath import nra_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    input  nra_cmd_t         cmd,
    output nra_stat_t        stat,
    input  logic             out_ready,
    output logic             out_valid,
    output pixel_t           out_data
);
    localparam int REG_MAX = (2 ** REG_W) - 1;
    localparam int SAT     = (MAX_DIM > REG_MAX) ? REG_MAX : MAX_DIM;
    localparam int DIM_W   = $clog2(SAT + 1);
    localparam int CNT_W   = $clog2(SAT);
    localparam int STEP_W  = DIM_W + FRAC_BITS;
    localparam int XP_W    = CNT_W + STEP_W;
    localparam int XW      = XP_W - FRAC_BITS;
    localparam int DP_W    = CNT_W + DIM_W;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > REG_W'(SAT))
            r = DIM_W'(SAT);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    logic [REG_W-1:0] source_width_reg, source_height_reg;
    logic [REG_W-1:0] dest_width_reg, dest_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= REG_W'(1);
            source_height_reg <= REG_W'(1);
            dest_width_reg    <= REG_W'(1);
            dest_height_reg   <= REG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                CFG_DEST_WIDTH:    dest_width_reg    <= cfg_data;
                CFG_DEST_HEIGHT:   dest_height_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] sw, sh, dw, dh;

    assign sw = eff_dim(source_width_reg);
    assign sh = eff_dim(source_height_reg);
    assign dw = eff_dim(dest_width_reg);
    assign dh = eff_dim(dest_height_reg);

    // ratio dividers, x and y side by side
    logic              div_x_busy, div_y_busy;
    logic [STEP_W-1:0] quot_x, quot_y;

    nra_divider #(.N(STEP_W), .D(DIM_W)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({sw, FRAC_BITS'(0)}),
        .divisor  (dw),
        .busy     (div_x_busy),
        .quotient (quot_x)
    );

    nra_divider #(.N(STEP_W), .D(DIM_W)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({sh, FRAC_BITS'(0)}),
        .divisor  (dh),
        .busy     (div_y_busy),
        .quotient (quot_y)
    );

    logic [STEP_W-1:0] step_x_reg, step_y_reg;
    logic [CNT_W-1:0]  col_reg, row_reg;
    logic [CNT_W-1:0]  col_next, row_next;

    logic             wrap_col;
    logic [DIM_W-1:0] wrap_row_inc;
    logic [DIM_W-1:0] adv_col_inc, adv_row_inc;

    always_comb
    begin
        wrap_col     = (DIM_W'(col_reg) >= dw);
        wrap_row_inc = DIM_W'(row_reg) + (wrap_col ? DIM_W'(1) : DIM_W'(0));
        adv_col_inc  = DIM_W'(col_reg) + DIM_W'(1);
        adv_row_inc  = DIM_W'(row_reg) + DIM_W'(1);
        col_next     = col_reg;
        row_next     = row_reg;
        if (cmd.load_step)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.wrap_pos)
        begin
            // stale position after a size change mid-frame
            if (wrap_col)
                col_next = '0;
            row_next = (wrap_row_inc >= dh) ? '0 : CNT_W'(wrap_row_inc);
        end
        else if (cmd.out_load)
        begin
            if (adv_col_inc >= dw)
            begin
                col_next = '0;
                row_next = (adv_row_inc >= dh) ? '0 : CNT_W'(adv_row_inc);
            end
            else
                col_next = CNT_W'(adv_col_inc);
        end
    end

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_step)
            begin
                step_x_reg <= quot_x + 1'b1;
                step_y_reg <= quot_y + 1'b1;
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    logic [XP_W-1:0]  x_prod_reg, y_prod_reg;
    logic [DP_W-1:0]  d_prod_reg;
    logic             last_reg;
    logic [CNT_W-1:0] src_col_reg, src_row_reg;
    logic             clamped_reg;
    logic [IDX_W-1:0] dest_idx_reg;
    logic [DP_W-1:0]  s_prod_reg;
    pixel_t           out_data_reg;

    logic [XW-1:0] x_full, y_full;
    logic          x_over, y_over;

    always_comb
    begin
        x_full = XW'(x_prod_reg >> FRAC_BITS);
        y_full = XW'(y_prod_reg >> FRAC_BITS);
        x_over = (x_full >= XW'(sw));
        y_over = (y_full >= XW'(sh));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_pos)
        begin
            x_prod_reg <= XP_W'(col_reg) * XP_W'(step_x_reg);
            y_prod_reg <= XP_W'(row_reg) * XP_W'(step_y_reg);
            d_prod_reg <= DP_W'(row_reg) * DP_W'(dw);
            last_reg   <= (DIM_W'(col_reg) == dw - 1'b1) && (DIM_W'(row_reg) == dh - 1'b1);
        end
        if (cmd.clamp)
        begin
            src_col_reg  <= x_over ? CNT_W'(sw - 1'b1) : CNT_W'(x_full);
            src_row_reg  <= y_over ? CNT_W'(sh - 1'b1) : CNT_W'(y_full);
            clamped_reg  <= x_over | y_over;
            dest_idx_reg <= IDX_W'(d_prod_reg + DP_W'(col_reg));
        end
        if (cmd.mul_src)
            s_prod_reg <= DP_W'(src_row_reg) * DP_W'(sw);
        if (cmd.out_load)
        begin
            out_data_reg.dest_index   <= dest_idx_reg;
            out_data_reg.source_index <= IDX_W'(s_prod_reg + DP_W'(src_col_reg));
            out_data_reg.source_col   <= COORD_W'(src_col_reg);
            out_data_reg.source_row   <= COORD_W'(src_row_reg);
            out_data_reg.frame_last   <= last_reg;
            out_data_reg.edge_clamped <= clamped_reg;
        end
    end

    assign stat.div_busy = div_x_busy | div_y_busy;
    assign stat.out_busy = out_valid_reg & ~out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
endmodule

/* sv/nra_ctrl.sv */
module nra_ctrl import nra_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_restart,
    output logic      in_ready,
    input  nra_stat_t stat,
    output nra_cmd_t  cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_POS   = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_CLAMP = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_restart)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                        state_next = S_POS;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.load_step = 1'b1;
                    state_next    = S_POS;
                end
            end
            S_POS:
            begin
                cmd.wrap_pos = 1'b1;
                state_next   = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_pos = 1'b1;
                state_next  = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_src = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
